### sv/npl_pkg.sv
// Shared types and constants for the 3x3 neighbourhood pattern locator.
`timescale 1ns / 1ps
`default_nettype none
package npl_pkg;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_SIZE_W = 11;
  localparam int CFG_VAL_W  = 16;
  localparam int RES_W      = 11;
  localparam int OUT_DATA_W = 24;

  localparam logic [CFG_SIZE_W-1:0] RST_FRAME_WIDTH  = 11'd1024;
  localparam logic [CFG_SIZE_W-1:0] RST_FRAME_HEIGHT = 11'd1024;
  localparam logic [CFG_VAL_W-1:0]  RST_CENTRE_VALUE = 16'd42;
  localparam logic [CFG_VAL_W-1:0]  RST_RING_VALUE   = 16'd7;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_CENTRE_VALUE = 2'd2,
    REG_RING_VALUE   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_SIZE_W-1:0] frame_width;
    logic [CFG_SIZE_W-1:0] frame_height;
    logic [CFG_VAL_W-1:0]  centre_value;
    logic [CFG_VAL_W-1:0]  ring_value;
  } cfg_t;

  // control of the pixel sitting in the read-modify-write stage
  typedef struct packed {
    logic valid;
    logic first_col;
    logic last_px;
    logic interior;
  } s1_ctl_t;

  typedef struct packed {
    logic [RES_W-1:0] match_col;
    logic [RES_W-1:0] match_row;
  } result_t;

endpackage
`default_nettype wire

### sv/npl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module npl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### sv/npl_cfg.sv
// APB register file: frame size and the two match values.
`timescale 1ns / 1ps
`default_nettype none
module npl_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [npl_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [npl_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [npl_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready,
  output npl_pkg::cfg_t                  cfg
);
  import npl_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr;

  assign idx = reg_idx_t'(cfg_paddr[3:2]);
  assign wr  = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        REG_FRAME_WIDTH:  cfg_nxt.frame_width  = cfg_pwdata[CFG_SIZE_W-1:0];
        REG_FRAME_HEIGHT: cfg_nxt.frame_height = cfg_pwdata[CFG_SIZE_W-1:0];
        REG_CENTRE_VALUE: cfg_nxt.centre_value = cfg_pwdata[CFG_VAL_W-1:0];
        REG_RING_VALUE:   cfg_nxt.ring_value   = cfg_pwdata[CFG_VAL_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= RST_FRAME_WIDTH;
      cfg_r.frame_height <= RST_FRAME_HEIGHT;
      cfg_r.centre_value <= RST_CENTRE_VALUE;
      cfg_r.ring_value   <= RST_RING_VALUE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_FRAME_WIDTH:  cfg_prdata = CFG_DATA_W'(cfg_r.frame_width);
      REG_FRAME_HEIGHT: cfg_prdata = CFG_DATA_W'(cfg_r.frame_height);
      REG_CENTRE_VALUE: cfg_prdata = CFG_DATA_W'(cfg_r.centre_value);
      REG_RING_VALUE:   cfg_prdata = CFG_DATA_W'(cfg_r.ring_value);
      default:          cfg_prdata = '0;
    endcase
  end

  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

endmodule
`default_nettype wire

### sv/npl_match.sv
// 3x3 window registers, pattern compare and per-frame match tracking.
`timescale 1ns / 1ps
`default_nettype none
module npl_match #(
  parameter int PIXEL_BITS = 16,
  parameter int CW         = 10,
  parameter int RW         = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  npl_pkg::s1_ctl_t        ctl,
  input  logic [PIXEL_BITS-1:0]   px,
  input  logic [PIXEL_BITS-1:0]   top,
  input  logic [PIXEL_BITS-1:0]   mid,
  input  logic [CW-1:0]           col,
  input  logic [RW-1:0]           row,
  input  logic [PIXEL_BITS-1:0]   cv,
  input  logic [PIXEL_BITS-1:0]   rv,
  output logic                    res_push,
  output npl_pkg::result_t        res
);
  import npl_pkg::*;

  // win_r[column][row]; column 2 is the newest
  logic [PIXEL_BITS-1:0] win_r   [3][3];
  logic [PIXEL_BITS-1:0] win_nxt [3][3];
  logic                  row_matched_r;
  logic [RW-1:0]         found_row_r;
  logic [CW-1:0]         found_col_r;
  logic [RW-1:0]         found_row_nxt;
  logic [CW-1:0]         found_col_nxt;
  logic                  rm_eff;
  logic                  ring_ok;
  logic                  hit;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[0][r] = win_r[1][r];
      win_nxt[1][r] = win_r[2][r];
    end
    win_nxt[2][0] = top;
    win_nxt[2][1] = mid;
    win_nxt[2][2] = px;
  end

  always_comb begin
    ring_ok = 1'b1;
    for (int k = 0; k < 3; k++) begin
      for (int r = 0; r < 3; r++) begin
        if (!(k == 1 && r == 1) && win_nxt[k][r] != rv) begin
          ring_ok = 1'b0;
        end
      end
    end
  end

  assign rm_eff = ctl.first_col ? 1'b0 : row_matched_r;
  assign hit    = ctl.interior && !rm_eff && (win_nxt[1][1] == cv) && ring_ok;

  assign found_row_nxt = hit ? row : found_row_r;
  assign found_col_nxt = hit ? col : found_col_r;

  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_matched_r <= 1'b0;
      found_row_r   <= '0;
      found_col_r   <= '0;
    end else if (ctl.valid) begin
      if (ctl.last_px) begin
        row_matched_r <= 1'b0;
        found_row_r   <= '0;
        found_col_r   <= '0;
      end else begin
        row_matched_r <= rm_eff || hit;
        found_row_r   <= found_row_nxt;
        found_col_r   <= found_col_nxt;
      end
    end
  end

  assign res_push      = ctl.valid && ctl.last_px;
  assign res.match_row = RES_W'(found_row_nxt);
  assign res.match_col = RES_W'(found_col_nxt);

endmodule
`default_nettype wire

### sv/npl_outq.sv
// Two-entry result queue: output register plus skid register.
`timescale 1ns / 1ps
`default_nettype none
module npl_outq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  npl_pkg::result_t               din,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [npl_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]                     count
);
  import npl_pkg::*;

  logic    head_vld_r, head_vld_nxt;
  logic    skid_vld_r, skid_vld_nxt;
  result_t head_r, head_nxt;
  result_t skid_r, skid_nxt;
  logic    pop;

  assign pop = head_vld_r && out_tready;

  always_comb begin
    head_vld_nxt = head_vld_r;
    skid_vld_nxt = skid_vld_r;
    head_nxt     = head_r;
    skid_nxt     = skid_r;
    if (pop) begin
      head_vld_nxt = skid_vld_r;
      head_nxt     = skid_r;
      skid_vld_nxt = 1'b0;
    end
    if (push) begin
      if (!head_vld_nxt) begin
        head_vld_nxt = 1'b1;
        head_nxt     = din;
      end else begin
        skid_vld_nxt = 1'b1;
        skid_nxt     = din;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      head_vld_r <= head_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = head_vld_r;
  assign out_tdata  = OUT_DATA_W'({head_r.match_col, head_r.match_row});
  assign count      = {head_vld_r && skid_vld_r, head_vld_r ^ skid_vld_r};

endmodule
`default_nettype wire

### sv/neighbourhood_pattern_locator_top.sv
// Top level of the 3x3 neighbourhood pattern locator.
`timescale 1ns / 1ps
`default_nettype none
// Takes one signed pixel a clock in raster order and looks for a 3x3 window whose centre
// equals centre_value and whose eight neighbours equal ring_value. One word leaves per
// frame after its last pixel is taken: 1-based row and column of the first match in the
// last row holding any match, or 0,0. The two line stores live in one RAM row per
// column, read at accept and written back the next cycle, so the block takes a pixel
// every clock; it stalls only while a clearing pass after reset zeroes the line RAM, or
// when the result queue is full or holds one word with another in stage 1. Frame size
// changes take effect on the next pixel; write registers only while the block is idle.
module neighbourhood_pattern_locator_top #(
  parameter int MAX_COLS   = 1024,
  parameter int MAX_ROWS   = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((PIXEL_BITS + 7) / 8) * 8-1:0] in_tdata,   // [PIXEL_BITS-1:0] pixel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [npl_pkg::OUT_DATA_W-1:0]      out_tdata,  // [10:0] match_row, [21:11] match_col
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [npl_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [npl_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [npl_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);
  import npl_pkg::*;

  localparam int CW  = $clog2(MAX_COLS);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CSW = (CW + 1 > CFG_SIZE_W) ? CW + 1 : CFG_SIZE_W;
  localparam int RSW = (RW + 1 > CFG_SIZE_W) ? RW + 1 : CFG_SIZE_W;
  localparam int EW  = 2 * PIXEL_BITS;

  cfg_t cfg;

  npl_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .cfg        (cfg)
  );

  // clamped frame size
  logic [CSW-1:0] fw_ext, w;
  logic [RSW-1:0] fh_ext, h;

  assign fw_ext = CSW'(cfg.frame_width);
  assign fh_ext = RSW'(cfg.frame_height);
  assign w = (fw_ext == '0) ? CSW'(1) : ((fw_ext > CSW'(MAX_COLS)) ? CSW'(MAX_COLS) : fw_ext);
  assign h = (fh_ext == '0) ? RSW'(1) : ((fh_ext > RSW'(MAX_ROWS)) ? RSW'(MAX_ROWS) : fh_ext);

  logic [PIXEL_BITS-1:0] cv, rv;
  assign cv = PIXEL_BITS'($signed(cfg.centre_value));
  assign rv = PIXEL_BITS'($signed(cfg.ring_value));

  // clearing pass over the line RAM
  logic          clr_active_r;
  logic [CW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == CW'(MAX_COLS - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // stage 0: raster counters and RAM read
  logic          accept;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] c0;
  logic          last_col, last_row;
  logic [1:0]    oq_count;

  // stage 1: read-modify-write
  s1_ctl_t               s1_ctl_r;
  logic [PIXEL_BITS-1:0] s1_px_r;
  logic [CW-1:0]         s1_col_r;
  logic [RW-1:0]         s1_row_r;
  logic                  s1_fwd_r;
  logic [EW-1:0]         s1_fwd_data_r;
  logic [EW-1:0]         rd_data, ent, wr_data;
  logic [PIXEL_BITS-1:0] top, mid;
  logic                  res_push;
  result_t               res;
  logic                  s1_res_pend;

  assign s1_res_pend = s1_ctl_r.valid && s1_ctl_r.last_px;
  assign in_tready = !clr_active_r && (oq_count != 2'd2) && !(oq_count == 2'd1 && s1_res_pend);
  assign accept    = in_tvalid && in_tready;

  assign c0       = (CSW'(col_r) >= w) ? '0 : col_r;
  assign last_col = (CSW'(c0) + 1'b1) >= w;
  assign last_row = (RSW'(row_r) + 1'b1) >= h;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      priority if (last_col && last_row) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (last_col) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
      end else begin
        col_nxt = c0 + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      s1_ctl_r <= '0;
    end else begin
      col_r              <= col_nxt;
      row_r              <= row_nxt;
      s1_ctl_r.valid     <= accept;
      s1_ctl_r.first_col <= (c0 == '0);
      s1_ctl_r.last_px   <= last_col && last_row;
      s1_ctl_r.interior  <= (row_r >= RW'(2)) && (c0 >= CW'(2));
    end
  end

  // same column read while stage 1 writes it (one-column frames): forward the write
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r       <= in_tdata[PIXEL_BITS-1:0];
      s1_col_r      <= c0;
      s1_row_r      <= row_r;
      s1_fwd_r      <= s1_ctl_r.valid && (s1_col_r == c0);
      s1_fwd_data_r <= wr_data;
    end
  end

  // entry layout: upper line in the low half, middle line in the high half
  assign ent     = s1_fwd_r ? s1_fwd_data_r : rd_data;
  assign top     = ent[PIXEL_BITS-1:0];
  assign mid     = ent[EW-1:PIXEL_BITS];
  assign wr_data = {s1_px_r, mid};

  npl_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_COLS)
  ) u_line_ram (
    .clk  (clk),
    .we   (clr_active_r || s1_ctl_r.valid),
    .waddr(clr_active_r ? clr_addr_r : s1_col_r),
    .wdata(clr_active_r ? '0 : wr_data),
    .re   (accept),
    .raddr(c0),
    .rdata(rd_data)
  );

  npl_match #(
    .PIXEL_BITS(PIXEL_BITS),
    .CW        (CW),
    .RW        (RW)
  ) u_match (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (s1_ctl_r),
    .px      (s1_px_r),
    .top     (top),
    .mid     (mid),
    .col     (s1_col_r),
    .row     (s1_row_r),
    .cv      (cv),
    .rv      (rv),
    .res_push(res_push),
    .res     (res)
  );

  npl_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .din       (res),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .count     (oq_count)
  );

endmodule
`default_nettype wire

### tb/neighbourhood_pattern_locator_top_tb.sv
// Self-checking testbench for the 3x3 neighbourhood pattern locator top level.
`timescale 1ns / 1ps
module neighbourhood_pattern_locator_top_tb;
  import npl_pkg::*;

  localparam int MAX_COLS      = 1024;
  localparam int MAX_ROWS      = 1024;
  localparam int STALL_LIMIT   = 4000;  // covers the line RAM clear after reset
  localparam int SETTLE_CYCLES = 8;
  localparam int ITEM_TARGET   = 500;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [15:0]           in_tdata;    // [15:0] pixel
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;   // [10:0] match_row, [21:11] match_col
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  neighbourhood_pattern_locator_top #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .PIXEL_BITS(16)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Tracks the window search frame by frame and holds the match words still owed.
  class match_predictor;
    logic [CFG_SIZE_W-1:0] width_r;
    logic [CFG_SIZE_W-1:0] height_r;
    logic [CFG_VAL_W-1:0]  centre_r;
    logic [CFG_VAL_W-1:0]  ring_r;
    logic [15:0]           upper_line[MAX_COLS];
    logic [15:0]           middle_line[MAX_COLS];
    logic [15:0]           win[9];
    int                    row_cnt;
    int                    col_cnt;
    logic [RES_W-1:0]      hit_row;
    logic [RES_W-1:0]      hit_col;
    bit                    row_hit;
    result_t               owed_matches[$];
    int                    errors;

    function new();
      width_r  = RST_FRAME_WIDTH;
      height_r = RST_FRAME_HEIGHT;
      centre_r = RST_CENTRE_VALUE;
      ring_r   = RST_RING_VALUE;
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      row_cnt = 0;
      col_cnt = 0;
      hit_row = '0;
      hit_col = '0;
      row_hit = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_FRAME_WIDTH:  width_r  = v[CFG_SIZE_W-1:0];
        REG_FRAME_HEIGHT: height_r = v[CFG_SIZE_W-1:0];
        REG_CENTRE_VALUE: centre_r = v[CFG_VAL_W-1:0];
        REG_RING_VALUE:   ring_r   = v[CFG_VAL_W-1:0];
        default: ;
      endcase
    endfunction

    // zero acts as one, oversize saturates
    function int cols();
      if (width_r == 0) return 1;
      return (width_r > MAX_COLS) ? MAX_COLS : int'(width_r);
    endfunction

    function int rows();
      if (height_r == 0) return 1;
      return (height_r > MAX_ROWS) ? MAX_ROWS : int'(height_r);
    endfunction

    function bit in_frame();
      return (row_cnt != 0) || (col_cnt != 0);
    endfunction

    // pixels still needed to close the current frame under the present size
    function int pixels_left();
      int w;
      int h;
      int c;
      w = cols();
      h = rows();
      c = (col_cnt >= w) ? 0 : col_cnt;
      if (row_cnt + 1 >= h) return w - c;
      return (w - c) + (h - 1 - row_cnt) * w;
    endfunction

    function void take_pixel(logic [15:0] px);
      int w;
      int h;
      int c;
      logic [15:0] top;
      logic [15:0] mid;
      bit hit;
      result_t r;
      w = cols();
      h = rows();
      if (col_cnt >= w) col_cnt = 0;
      c = col_cnt;
      if (c == 0) row_hit = 1'b0;
      top = upper_line[c];
      mid = middle_line[c];
      upper_line[c]  = mid;
      middle_line[c] = px;
      for (int k = 0; k < 3; k++) begin
        win[k*3]   = win[k*3+1];
        win[k*3+1] = win[k*3+2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = px;
      if (row_cnt >= 2 && c >= 2 && !row_hit && win[4] == centre_r) begin
        hit = 1'b1;
        for (int k = 0; k < 9; k++)
          if (k != 4 && win[k] != ring_r) hit = 1'b0;
        if (hit) begin
          // window centre is one row up and one column left, 1-based here
          hit_row = row_cnt[RES_W-1:0];
          hit_col = c[RES_W-1:0];
          row_hit = 1'b1;
        end
      end
      if (c + 1 >= w && row_cnt + 1 >= h) begin
        r.match_row = hit_row;
        r.match_col = hit_col;
        owed_matches.push_back(r);
        row_cnt = 0;
        col_cnt = 0;
        hit_row = '0;
        hit_col = '0;
        row_hit = 1'b0;
      end else if (c + 1 >= w) begin
        col_cnt = 0;
        row_cnt++;
      end else begin
        col_cnt = c + 1;
      end
    endfunction

    function void check_match(logic [OUT_DATA_W-1:0] word);
      result_t got;
      result_t want;
      got = word[2*RES_W-1:0];
      if (owed_matches.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual row %0d col %0d",
                 $time, got.match_row, got.match_col);
        errors++;
        return;
      end
      want = owed_matches.pop_front();
      if (got.match_row !== want.match_row) begin
        $display("%0t: match_row mismatch, expected %0d, actual %0d",
                 $time, want.match_row, got.match_row);
        errors++;
      end
      if (got.match_col !== want.match_col) begin
        $display("%0t: match_col mismatch, expected %0d, actual %0d",
                 $time, want.match_col, got.match_col);
        errors++;
      end
    endfunction

    function int pending();
      return owed_matches.size();
    endfunction
  endclass

  match_predictor locator = new();
  int  pixels_sent;
  int  stall_cycles;
  bit  in_steady;
  bit  out_steady;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // handshake monitor and watchdog
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) locator.take_pixel(in_tdata);
    if (rst_n && out_tvalid && out_tready) locator.check_match(out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side backpressure
  initial begin
    int gap;
    out_tready <= 1'b0;
    forever begin
      gap = out_steady ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic write_cfg(reg_idx_t idx, logic [15:0] val);
    logic [31:0] junk;
    junk = $urandom;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT) ?
                   {junk[31:11], val[10:0]} : {junk[31:16], val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    locator.write_reg(idx, cfg_pwdata);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_frame(logic [10:0] w, logic [10:0] h, logic [15:0] cv, logic [15:0] rv);
    write_cfg(REG_FRAME_WIDTH, {5'd0, w});
    write_cfg(REG_FRAME_HEIGHT, {5'd0, h});
    write_cfg(REG_CENTRE_VALUE, cv);
    write_cfg(REG_RING_VALUE, rv);
  endtask

  task automatic send_pixel(logic [15:0] px);
    int gap;
    gap = in_steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    pixels_sent++;
  endtask

  // wait for the block to go quiet before touching registers
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (locator.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // noise, dense ring/centre mix, or ring background with sparse centers
  function automatic logic [15:0] pick_pixel(int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      0: return 16'($urandom);
      1: return (r < 70) ? locator.ring_r : (r < 90) ? locator.centre_r : 16'($urandom);
      default: return (r < 93) ? locator.ring_r : (r < 98) ? locator.centre_r : 16'($urandom);
    endcase
  endfunction

  task automatic send_pixels(int n, int mode);
    for (int i = 0; i < n; i++) send_pixel(pick_pixel(mode));
  endtask

  initial begin
    int frames;
    int n;
    int mode;
    int pick;
    logic [10:0] w;
    logic [10:0] h;
    logic [15:0] cv;
    logic [15:0] rv;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    pixels_sent = 0;
    stall_cycles = 0;
    in_steady = 1'b0;
    out_steady = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // smallest frame with an interior pixel, extreme values, match in the middle
    set_frame(11'd3, 11'd3, 16'h8000, 16'h7fff);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 16'h8000 : 16'h7fff);
    drain();
    // zero size acts as a one-pixel frame
    set_frame(11'd0, 11'd0, 16'h0000, 16'hffff);
    send_pixel(16'h0000);
    send_pixel(16'hffff);
    drain();
    // two by two has no interior pixel
    set_frame(11'd2, 11'd2, 16'h0000, 16'hffff);
    send_pixel(16'hffff);
    send_pixel(16'h0000);
    send_pixel(16'hffff);
    send_pixel(16'hffff);
    drain();
    // shrink the frame mid-row: column wraps and the row limit ends the frame
    set_frame(11'd5, 11'd4, 16'h0000, 16'hffff);
    send_pixels(7, 1);
    drain();
    write_cfg(REG_FRAME_WIDTH, 16'd2);
    write_cfg(REG_FRAME_HEIGHT, 16'd1);
    send_pixels(locator.pixels_left(), 1);

    while (pixels_sent < ITEM_TARGET) begin
      drain();
      pick = $urandom_range(0, 5);
      cv = (pick == 0) ? 16'h8000 : (pick == 1) ? 16'h7fff : 16'($urandom);
      rv = (pick == 0) ? 16'h7fff : (pick == 1) ? 16'h8000 :
           (pick == 2) ? cv : 16'($urandom);
      frames = $urandom_range(1, 4);
      w = 11'($urandom_range(0, 8));
      h = 11'($urandom_range(0, 8));
      set_frame(w, h, cv, rv);
      in_steady  = ($urandom_range(0, 3) == 0);
      out_steady = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 3);
      if (locator.in_frame()) send_pixels(locator.pixels_left(), mode);
      for (int f = 0; f < frames; f++) begin
        mode = $urandom_range(0, 3);
        n = locator.cols() * locator.rows();
        // sometimes leave the last frame open so the next setting lands mid-frame
        if (f == frames - 1 && n > 1 && $urandom_range(0, 3) == 0)
          n = $urandom_range(1, n - 1);
        send_pixels(n, mode);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (locator.errors == 0 && locator.pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
